/* hw/rtl/rc4fnv_pkg.sv */
// Shared types and constants for the RC4 stream crypt block with FNV-1a checksum.
package rc4fnv_pkg;

  localparam logic [31:0] FNV_OFFSET = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME  = 32'd16777619;

  localparam logic OP_KEY = 1'b0;
  localparam logic OP_MSG = 1'b1;

  typedef struct packed {
    logic       operation;
    logic [7:0] value;
    logic       last;
  } in_t;

  typedef struct packed {
    logic [7:0]  crypt_byte;
    logic        end_of_message;
    logic [31:0] checksum;
  } out_t;

  typedef enum logic [2:0] {
    RA_NEXT_I,
    RA_K,
    RA_NEXT_K,
    RA_KSA_J,
    RA_PRGA_J
  } ra_sel_e;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_INIT,
    WR_K_SWAP,
    WR_J_HOLD,
    WR_I_SWAP
  } wr_sel_e;

  typedef struct packed {
    ra_sel_e ra_sel;
    wr_sel_e wr_sel;
    logic    key_wr;
    logic    msg_cap;
    logic    sched_start;
    logic    k_inc;
    logic    ksa_mix;
    logic    prga_init;
    logic    step_i;
    logic    prga_j;
    logic    prga_swap;
    logic    finish;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic k_last;
    logic last;
  } sts_t;

endpackage

/* hw/rtl/rc4fnv_dp.sv */
// Datapath: S-box and key memories, RC4 index registers, FNV-1a hash and output register.
module rc4fnv_dp import rc4fnv_pkg::*; #(
  parameter int unsigned MAX_KEY_BYTES = 256
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic cfg_wdata_i,
  input  in_t  in_data_i,
  input  cmd_t cmd_i,
  output sts_t sts_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  localparam int unsigned KeyAw   = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
  localparam int unsigned KeyCw   = $clog2(MAX_KEY_BYTES + 1);
  localparam int unsigned KeyCmpW = KeyCw + 1;

  logic [7:0] sbox_mem [256];
  logic [7:0] key_mem [MAX_KEY_BYTES];

  logic [7:0]       i_q, j_q, k_q;
  logic [7:0]       hold_q, t_q, rda_q, rdb_q, krd_q;
  logic [7:0]       val_q;
  logic             last_q;
  logic [KeyAw-1:0] kidx_q;
  logic [KeyCw-1:0] key_count_q;
  logic             key_complete_q;
  logic             dir_q;
  logic [31:0]      hash_q;
  logic             out_valid_q;
  out_t             out_q;

  logic [7:0]       kb, ksa_j, prga_j, t_d, ra, wa, wd, ks, res, hash_byte;
  logic             we, out_free, load, key_room, kidx_wrap;
  logic [31:0]      hash_nxt;
  logic [KeyCw-1:0] key_base, key_n;

  assign kb        = (key_count_q == '0) ? 8'h00 : krd_q;
  assign ksa_j     = j_q + rda_q + kb;
  assign prga_j    = j_q + rda_q;
  assign t_d       = hold_q + rda_q;
  assign ks        = (t_q == j_q) ? hold_q : rdb_q;
  assign res       = val_q ^ ks;
  assign hash_byte = dir_q ? res : val_q;
  assign hash_nxt  = (hash_q ^ {24'h000000, hash_byte}) * FNV_PRIME;
  assign out_free  = !out_valid_q || out_ready_i;
  assign load      = cmd_i.finish && out_free;
  assign key_base  = key_complete_q ? '0 : key_count_q;
  assign key_room  = key_base < KeyCw'(MAX_KEY_BYTES);
  assign key_n     = (key_count_q == '0) ? KeyCw'(1) : key_count_q;
  assign kidx_wrap = (KeyCmpW'(kidx_q) + KeyCmpW'(1)) == KeyCmpW'(key_n);

  always_comb begin
    case (cmd_i.ra_sel)
      RA_NEXT_I: ra = i_q + 8'd1;
      RA_K:      ra = k_q;
      RA_NEXT_K: ra = k_q + 8'd1;
      RA_KSA_J:  ra = ksa_j;
      RA_PRGA_J: ra = prga_j;
      default:   ra = k_q;
    endcase
  end

  always_comb begin
    we = 1'b1;
    wa = k_q;
    wd = k_q;
    case (cmd_i.wr_sel)
      WR_INIT: begin
        wa = k_q;
        wd = k_q;
      end
      WR_K_SWAP: begin
        wa = k_q;
        wd = rda_q;
      end
      WR_J_HOLD: begin
        wa = j_q;
        wd = hold_q;
      end
      WR_I_SWAP: begin
        wa = i_q;
        wd = rda_q;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      sbox_mem[wa] <= wd;
    end
    rda_q <= (we && wa == ra) ? wd : sbox_mem[ra];
    if (cmd_i.prga_swap) begin
      t_q   <= t_d;
      rdb_q <= (we && wa == t_d) ? wd : sbox_mem[t_d];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.key_wr && key_room) begin
      key_mem[key_base[KeyAw-1:0]] <= in_data_i.value;
    end
    krd_q <= key_mem[kidx_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ksa_mix || cmd_i.prga_j) begin
      hold_q <= rda_q;
    end
    if (cmd_i.msg_cap) begin
      val_q  <= in_data_i.value;
      last_q <= in_data_i.last;
    end
    if (load) begin
      out_q.crypt_byte     <= res;
      out_q.end_of_message <= last_q;
      out_q.checksum       <= hash_nxt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q          <= 1'b0;
      key_count_q    <= '0;
      key_complete_q <= 1'b1;
      i_q            <= 8'h00;
      j_q            <= 8'h00;
      k_q            <= 8'h00;
      kidx_q         <= '0;
      hash_q         <= FNV_OFFSET;
      out_valid_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        dir_q <= cfg_wdata_i;
      end
      if (cmd_i.key_wr) begin
        key_complete_q <= in_data_i.last;
        key_count_q    <= key_room ? key_base + KeyCw'(1) : key_base;
      end else if (cmd_i.sched_start) begin
        key_complete_q <= 1'b1;
      end
      if (cmd_i.sched_start) begin
        k_q <= 8'h00;
      end else if (cmd_i.k_inc) begin
        k_q <= k_q + 8'd1;
      end
      if (cmd_i.sched_start || cmd_i.prga_init) begin
        j_q <= 8'h00;
      end else if (cmd_i.ksa_mix) begin
        j_q <= ksa_j;
      end else if (cmd_i.prga_j) begin
        j_q <= prga_j;
      end
      if (cmd_i.sched_start) begin
        i_q <= 8'h00;
      end else if (cmd_i.step_i) begin
        i_q <= i_q + 8'd1;
      end
      if (cmd_i.sched_start) begin
        kidx_q <= '0;
      end else if (cmd_i.ksa_mix) begin
        kidx_q <= kidx_wrap ? '0 : kidx_q + KeyAw'(1);
      end
      if (cmd_i.sched_start) begin
        hash_q <= FNV_OFFSET;
      end else if (load) begin
        hash_q <= hash_nxt;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.out_free = out_free;
  assign sts_o.k_last   = (k_q == 8'hFF);
  assign sts_o.last     = last_q;
  assign out_valid_o    = out_valid_q;
  assign out_data_o     = out_q;

  a_checksum_tracks_hash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load && !cmd_i.sched_start |=> out_valid_q && out_q.checksum == hash_q)
    else $error("output checksum differs from running hash");

  a_key_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    key_count_q <= KeyCw'(MAX_KEY_BYTES))
    else $error("key count beyond key store depth");

endmodule

/* hw/rtl/rc4fnv_ctrl.sv */
// Controller: sequences request intake, key schedule, keystream steps and result handoff.
module rc4fnv_ctrl import rc4fnv_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_op_i,
  input  sts_t sts_i,
  output logic in_ready_o,
  output cmd_t cmd_o
);

  typedef enum logic [9:0] {
    ST_IDLE = 10'b0000000001,
    ST_INIT = 10'b0000000010,
    ST_KA   = 10'b0000000100,
    ST_KB   = 10'b0000001000,
    ST_KC   = 10'b0000010000,
    ST_KD   = 10'b0000100000,
    ST_P0   = 10'b0001000000,
    ST_P1   = 10'b0010000000,
    ST_P2   = 10'b0100000000,
    ST_FIN  = 10'b1000000000
  } state_e;

  state_e state_q, state_d;
  logic   in_msg_q, in_msg_d;
  logic   take;
  cmd_t   cmd;

  always_comb begin
    cmd         = '0;
    cmd.ra_sel  = RA_NEXT_I;
    cmd.wr_sel  = WR_NONE;
    state_d     = state_q;
    in_msg_d    = in_msg_q;
    in_ready_o  = 1'b0;
    take        = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        take       = in_valid_i;
      end
      ST_FIN: begin
        cmd.finish = 1'b1;
        cmd.wr_sel = WR_J_HOLD;
        if (sts_i.out_free) begin
          in_ready_o = 1'b1;
          take       = in_valid_i;
          state_d    = ST_IDLE;
        end
      end
      ST_INIT: begin
        cmd.wr_sel = WR_INIT;
        cmd.k_inc  = 1'b1;
        if (sts_i.k_last) begin
          state_d = ST_KA;
        end
      end
      ST_KA: begin
        cmd.ra_sel = RA_K;
        state_d    = ST_KB;
      end
      ST_KB: begin
        cmd.ra_sel  = RA_KSA_J;
        cmd.ksa_mix = 1'b1;
        state_d     = ST_KC;
      end
      ST_KC: begin
        cmd.wr_sel = WR_K_SWAP;
        state_d    = ST_KD;
      end
      ST_KD: begin
        cmd.wr_sel = WR_J_HOLD;
        cmd.ra_sel = RA_NEXT_K;
        cmd.k_inc  = 1'b1;
        if (sts_i.k_last) begin
          cmd.prga_init = 1'b1;
          state_d       = ST_P0;
        end else begin
          state_d = ST_KB;
        end
      end
      ST_P0: begin
        cmd.step_i = 1'b1;
        state_d    = ST_P1;
      end
      ST_P1: begin
        cmd.ra_sel = RA_PRGA_J;
        cmd.prga_j = 1'b1;
        state_d    = ST_P2;
      end
      ST_P2: begin
        cmd.wr_sel    = WR_I_SWAP;
        cmd.prga_swap = 1'b1;
        if (sts_i.last) begin
          in_msg_d = 1'b0;
        end
        state_d = ST_FIN;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (take) begin
      if (in_op_i == OP_MSG) begin
        cmd.msg_cap = 1'b1;
        if (in_msg_q) begin
          cmd.step_i = 1'b1;
          state_d    = ST_P1;
        end else begin
          cmd.sched_start = 1'b1;
          in_msg_d        = 1'b1;
          state_d         = ST_INIT;
        end
      end else if (!in_msg_q) begin
        cmd.key_wr = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      in_msg_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      in_msg_q <= in_msg_d;
    end
  end

  assign cmd_o = cmd;

  a_sched_to_stream: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_KD && sts_i.k_last |=> state_q == ST_P0 && in_msg_q)
    else $error("key schedule did not hand over to the keystream");

  a_stream_in_msg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_P1 |-> in_msg_q)
    else $error("keystream step outside a message");

  a_fin_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FIN && !sts_i.out_free |=> state_q == ST_FIN)
    else $error("result dropped while the output was stalled");

endmodule

/* hw/rtl/rc4_stream_crypt_with_fnv_checksum.sv */
// Top level of the RC4 stream crypt block with FNV-1a checksum.
// Requests enter on in_valid_i/in_ready_o with in_data_i: operation 0 stores a key
// byte, operation 1 crypts a message byte; last closes the key or the message.
// Key bytes give no result. Each message byte gives one result on out_valid_o/
// out_ready_i: the crypted byte, an end-of-message flag and the running FNV-1a
// checksum of the plaintext. cfg_we_i/cfg_wdata_i set the direction (0 encrypt,
// 1 decrypt); the user must write them only while the block is idle.
// The block itself does not enforce this. The first message byte of each message
// starts the key schedule: the S-box is rebuilt as the identity, then states KB,
// KC and KD mix each entry with the key. Every further byte runs through P1, P2 and
// FIN, and the next byte is taken only once the result is loaded; this is set by
// the chain of three dependent S-box reads at i, j and the sum of their entries.
// When the receiver stalls, the finished result waits in the output register and
// the block stops after completing the next byte. Reset empties the output,
// clears the stored key count, ends any message and selects encryption.
module rc4_stream_crypt_with_fnv_checksum import rc4fnv_pkg::*; #(
  parameter int unsigned MAX_KEY_BYTES = 256
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic cfg_wdata_i,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  cmd_t cmd;
  sts_t sts;

  rc4fnv_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_op_i    (in_data_i.operation),
    .sts_i      (sts),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd)
  );

  rc4fnv_dp #(
    .MAX_KEY_BYTES (MAX_KEY_BYTES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

/* tb/rc4fnv_crypt_checker.sv */
// Checker that predicts the crypt byte and checksum of every message request and compares results.
module rc4fnv_crypt_checker import rc4fnv_pkg::*; #(
  parameter int unsigned MAX_KEY_BYTES = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  in_t         in_data_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  out_t        out_data_i,
  output int unsigned mismatch_count_o,
  output int unsigned results_awaited_o
);

  logic [7:0]  sbox [256];
  logic [7:0]  key_bytes [256];
  int unsigned key_len;
  logic        key_closed;
  logic        msg_open;
  logic        decrypting;
  logic [7:0]  si;
  logic [7:0]  sj;
  logic [31:0] plain_hash;
  out_t        expected_results [$];
  out_t        want;
  out_t        fresh;
  int unsigned mismatches;

  function automatic void swap_sbox(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] t;
    t = sbox[a];
    sbox[a] = sbox[b];
    sbox[b] = t;
  endfunction

  function automatic bit predict_crypt(input in_t req, output out_t res);
    int unsigned span;
    logic [7:0]  mix;
    logic [7:0]  kb;
    logic [7:0]  ks_idx;
    res = '0;
    if (req.operation == OP_KEY) begin
      if (msg_open) return 1'b0;
      if (key_closed) begin
        key_len = 0;
        key_closed = 1'b0;
      end
      if (key_len < MAX_KEY_BYTES && key_len < 256) begin
        key_bytes[key_len] = req.value;
        key_len++;
      end
      if (req.last) key_closed = 1'b1;
      return 1'b0;
    end
    if (!msg_open) begin
      span = (key_len == 0) ? 1 : key_len;
      mix = '0;
      for (int k = 0; k < 256; k++) sbox[k] = k[7:0];
      for (int k = 0; k < 256; k++) begin
        kb = (key_len == 0) ? 8'h00 : key_bytes[k % span];
        mix = mix + sbox[k] + kb;
        swap_sbox(k[7:0], mix);
      end
      key_closed = 1'b1;
      si = '0;
      sj = '0;
      plain_hash = FNV_OFFSET;
      msg_open = 1'b1;
    end
    si = si + 8'd1;
    sj = sj + sbox[si];
    swap_sbox(si, sj);
    ks_idx = sbox[si] + sbox[sj];
    res.crypt_byte = req.value ^ sbox[ks_idx];
    plain_hash = (plain_hash ^ {24'h0, decrypting ? res.crypt_byte : req.value}) * FNV_PRIME;
    res.end_of_message = req.last;
    res.checksum = plain_hash;
    if (req.last) msg_open = 1'b0;
    return 1'b1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 256; k++) sbox[k] = k[7:0];
      key_len = 0;
      key_closed = 1'b1;
      msg_open = 1'b0;
      si = '0;
      sj = '0;
      plain_hash = FNV_OFFSET;
      decrypting = 1'b0;
      expected_results.delete();
      mismatches = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result %02h/%0b/%08h arrived with no request waiting", $time,
                     out_data_i.crypt_byte, out_data_i.end_of_message, out_data_i.checksum);
        end else begin
          want = expected_results.pop_front();
          if (want.crypt_byte !== out_data_i.crypt_byte ||
              want.end_of_message !== out_data_i.end_of_message ||
              want.checksum !== out_data_i.checksum) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: mismatch crypt_byte exp %02h got %02h, end_of_message exp %0b got %0b, %s",
                       $time, want.crypt_byte, out_data_i.crypt_byte, want.end_of_message,
                       out_data_i.end_of_message,
                       $sformatf("checksum exp %08h got %08h", want.checksum, out_data_i.checksum));
          end
        end
      end
      if (cfg_we_i) decrypting = cfg_wdata_i;
      if (in_valid_i && in_ready_i) begin
        if (predict_crypt(in_data_i, fresh)) expected_results.push_back(fresh);
      end
    end
    mismatch_count_o <= mismatches;
    results_awaited_o <= expected_results.size();
  end

endmodule

/* tb/rc4_stream_crypt_with_fnv_checksum_test.sv */
// Testbench top for the RC4 stream crypt block: drives key and message requests and gives the verdict.
module rc4_stream_crypt_with_fnv_checksum_test;
  import rc4fnv_pkg::*;

  localparam int unsigned KEY_CAP       = 256;
  localparam int unsigned ITEM_TARGET   = 1950;
  localparam int unsigned IDLE_LIMIT    = 6000;
  localparam int unsigned LONG_HOLD     = 300;
  localparam int unsigned DRAIN_CYCLES  = 1100;
  localparam int unsigned SETTLE_CYCLES = 8;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_PATTERN, RX_SPARSE} rx_mode_e;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_wdata_i;
  logic        in_valid_i;
  logic        in_ready_o;
  in_t         in_data_i;
  logic        out_valid_o;
  logic        out_ready_i;
  out_t        out_data_o;
  int unsigned mismatch_count;
  int unsigned results_awaited;
  int unsigned idle_cycles = 0;
  int unsigned burst_left;
  int unsigned rx_tick = 0;
  rx_mode_e    rx_mode;
  bit          sender_steady;
  bit          hold_wanted;
  bit          key_open;
  int unsigned items_sent;
  int unsigned msg_no;
  int unsigned key_len;
  int unsigned msg_len;

  rc4_stream_crypt_with_fnv_checksum #(
    .MAX_KEY_BYTES(KEY_CAP)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  rc4fnv_crypt_checker #(
    .MAX_KEY_BYTES(KEY_CAP)
  ) crypt_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .in_data_i        (in_data_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .out_data_i       (out_data_o),
    .mismatch_count_o (mismatch_count),
    .results_awaited_o(results_awaited)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("rc4_stream_crypt_with_fnv_checksum_test: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic offer_request(input logic op, input logic [7:0] val, input logic fin);
    in_t         req;
    int unsigned gap;
    if (burst_left == 0) begin
      gap = sender_steady ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12));
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    req.operation = op;
    req.value = val;
    req.last = fin;
    in_valid_i <= 1'b1;
    in_data_i <= req;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
    items_sent++;
  endtask

  task automatic set_direction(input logic dir);
    in_valid_i <= 1'b0;
    while (results_awaited != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= dir;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    out_ready_i = 1'b0;
    rx_mode = RX_OPEN;
    forever begin
      @(negedge clk_i);
      if (hold_wanted) begin
        // The receiver holds off once results flow, so the block fills and stalls new requests.
        out_ready_i <= 1'b0;
        while (!out_valid_o) @(negedge clk_i);
        repeat (LONG_HOLD) @(negedge clk_i);
        hold_wanted = 1'b0;
      end else begin
        if (rx_tick % 64 == 0) rx_mode = rx_mode_e'($urandom_range(0, 3));
        rx_tick++;
        case (rx_mode)
          RX_OPEN:    out_ready_i <= 1'b1;
          RX_COIN:    out_ready_i <= 1'($urandom_range(0, 1));
          RX_PATTERN: out_ready_i <= (rx_tick % 7) < 4;
          default:    out_ready_i <= ($urandom_range(0, 4) == 0);
        endcase
      end
    end
  end

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    burst_left = 0;
    sender_steady = 1'b0;
    hold_wanted = 1'b0;
    items_sent = 0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    set_direction(1'b0);

    // A message straight after reset runs with the empty key.
    offer_request(OP_MSG, 8'h00, 1'b0);
    offer_request(OP_MSG, 8'hFF, 1'b1);
    offer_request(OP_KEY, 8'h00, 1'b0);
    offer_request(OP_KEY, 8'hFF, 1'b0);
    offer_request(OP_KEY, 8'h5A, 1'b1);
    offer_request(OP_MSG, 8'hA5, 1'b0);
    offer_request(OP_MSG, 8'h00, 1'b0);
    offer_request(OP_MSG, 8'hFF, 1'b1);
    // A key request inside a message is ignored.
    offer_request(OP_MSG, 8'h80, 1'b0);
    offer_request(OP_KEY, 8'h7E, 1'b1);
    offer_request(OP_MSG, 8'h01, 1'b1);
    // The key is still open when the message starts.
    offer_request(OP_KEY, 8'h11, 1'b0);
    offer_request(OP_KEY, 8'h22, 1'b0);
    offer_request(OP_MSG, 8'h3C, 1'b1);
    // The direction changes between two bytes of one message.
    offer_request(OP_MSG, 8'h96, 1'b0);
    set_direction(1'b1);
    offer_request(OP_MSG, 8'h69, 1'b1);
    offer_request(OP_KEY, 8'h01, 1'b1);
    offer_request(OP_MSG, 8'hFE, 1'b1);

    msg_no = 0;
    while (items_sent < ITEM_TARGET) begin
      if (msg_no % 12 == 0) begin
        set_direction((msg_no / 12) % 2 == 0);
        sender_steady = ($urandom_range(0, 3) == 0);
      end
      if (msg_no == 3)
        key_len = KEY_CAP;
      else if (msg_no == 14)
        key_len = KEY_CAP + $urandom_range(1, 5);
      else if ($urandom_range(0, 9) < 7)
        key_len = ($urandom_range(0, 3) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
      else
        key_len = 0;
      key_open = ($urandom_range(0, 9) == 0);
      for (int unsigned k = 0; k < key_len; k++)
        offer_request(OP_KEY, 8'($urandom_range(0, 255)), (k == key_len - 1) && !key_open);
      if (msg_no == 6) begin
        hold_wanted = 1'b1;
        msg_len = 40;
      end else begin
        msg_len = ($urandom_range(0, 4) == 0) ? $urandom_range(25, 64) : $urandom_range(1, 24);
      end
      for (int unsigned b = 0; b < msg_len; b++) begin
        if ($urandom_range(0, 19) == 0)
          offer_request(OP_KEY, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        offer_request(OP_MSG, 8'($urandom_range(0, 255)), b == msg_len - 1);
      end
      msg_no++;
    end

    in_valid_i <= 1'b0;
    while (results_awaited != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (mismatch_count == 0 && results_awaited == 0) begin
      $display("rc4_stream_crypt_with_fnv_checksum_test: PASS");
    end else begin
      $display("rc4_stream_crypt_with_fnv_checksum_test: FAIL");
    end
    $finish;
  end

endmodule
